// ----- design/stsc_pkg.sv -----
// ----------------------------------------------------------------------
// Source token scanner package
// Shared types, scan mode codes, token kinds and byte codes.
// ----------------------------------------------------------------------
package stsc_pkg;

	// Scan mode codes
	localparam logic [3:0] MODE_IDLE    = 4'd0;
	localparam logic [3:0] MODE_COMMENT = 4'd1;
	localparam logic [3:0] MODE_IDENT   = 4'd2;
	localparam logic [3:0] MODE_PRAGMA  = 4'd3;
	localparam logic [3:0] MODE_INT     = 4'd4;
	localparam logic [3:0] MODE_FRAC    = 4'd5;
	localparam logic [3:0] MODE_EXP     = 4'd6;
	localparam logic [3:0] MODE_STR     = 4'd7;
	localparam logic [3:0] MODE_ESC     = 4'd8;

	// Token kinds
	localparam logic [3:0] KIND_EOF     = 4'd0;
	localparam logic [3:0] KIND_NEWLINE = 4'd1;
	localparam logic [3:0] KIND_INT     = 4'd2;
	localparam logic [3:0] KIND_FLOAT   = 4'd3;
	localparam logic [3:0] KIND_STRING  = 4'd4;
	localparam logic [3:0] KIND_IDENT   = 4'd5;
	localparam logic [3:0] KIND_PRAGMA  = 4'd6;
	localparam logic [3:0] KIND_COLON   = 4'd7;
	localparam logic [3:0] KIND_LBRACE  = 4'd8;
	localparam logic [3:0] KIND_RBRACE  = 4'd9;
	localparam logic [3:0] KIND_LBRACK  = 4'd10;
	localparam logic [3:0] KIND_RBRACK  = 4'd11;
	localparam logic [3:0] KIND_LPAREN  = 4'd12;
	localparam logic [3:0] KIND_RPAREN  = 4'd13;
	localparam logic [3:0] KIND_COMMA   = 4'd14;
	localparam logic [3:0] KIND_DOTDOT  = 4'd15;

	// Byte codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UE     = 8'h45;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LE     = 8'h65;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = 2;

	// One classified source byte
	typedef struct packed {
		logic [7:0] code;
		logic       is_end;
		logic       is_digit;
		logic       is_alnum;
		logic       is_name;
		logic       is_nameop;
	} char_t;

	localparam char_t CH_NONE = '0;

	// Head of the queue as seen by the back end
	typedef struct packed {
		logic  valid;
		char_t ch;
	} q_head_t;

	// One token
	typedef struct packed {
		logic [3:0]  kind;
		logic [23:0] start;
		logic [15:0] length;
		logic [19:0] line;
		logic [15:0] column;
		logic [63:0] value;
	} tok_t;

	// True when the scanner must see more bytes before it can act.
	function automatic logic need_more(input logic [3:0] mode, input logic [1:0] n,
		input logic ae, input char_t c0, input char_t c1);
		logic a0;
		logic a1;
		logic a2;
		logic r;
		a0 = (n != 2'd0) || ae;
		a1 = (n > 2'd1) || ae;
		a2 = (n == 2'd3) || ae;
		r = 1'b0;
		if (!a0) begin
			r = 1'b1;
		end else begin
			case (mode)
				MODE_IDLE: r = ((c0.code == CH_DOT) || (c0.code == CH_BANG)) && !a1;
				MODE_INT:  r = (c0.code == CH_DOT) && !a1;
				MODE_FRAC: r = ((c0.code == CH_LE) || (c0.code == CH_UE)) &&
					(!a1 || (!c1.is_digit &&
					((c1.code == CH_PLUS) || (c1.code == CH_MINUS)) && !a2));
				default:   r = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- design/stsc_front.sv -----
// ----------------------------------------------------------------------
// Scanner front end
// Accepts source bytes, classifies them and queues them for the back end.
// ----------------------------------------------------------------------
module stsc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       char_code,
	input  logic             end_of_input,
	output stsc_pkg::q_head_t head,
	input  logic             pop
);
	import stsc_pkg::*;

	char_t                mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   cnt_q;
	char_t                cls;
	logic                 push;
	logic                 do_pop;

	// A zero byte behaves like end of input.
	always_comb begin
		cls = CH_NONE;
		if (end_of_input || (char_code == CH_NUL)) begin
			cls.is_end = 1'b1;
		end else begin
			cls.code = char_code;
			cls.is_digit = char_code inside {[CH_0:CH_9]};
			cls.is_alnum = cls.is_digit || (char_code inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]});
			cls.is_name = cls.is_alnum ||
				(char_code inside {CH_UNDER, CH_MINUS, CH_QMARK, CH_EQ, CH_DOT});
			cls.is_nameop = cls.is_name || (char_code inside {CH_PLUS, CH_STAR, CH_SLASH,
				CH_PCT, CH_AT, CH_LT, CH_GT, CH_BANG, CH_AMP, CH_BAR, CH_CARET});
		end
	end

	assign in_stall = (cnt_q == (QPTR_BITS+1)'(QDEPTH));
	assign push = in_valid && !in_stall;
	assign do_pop = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.ch = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(do_pop);
		end
	end

endmodule

// ----- design/stsc_back.sv -----
// ----------------------------------------------------------------------
// Scanner back end
// Runs one scan step per cycle, unless stalled, over a three byte window and emits tokens.
// ----------------------------------------------------------------------
module stsc_back #(
	parameter int POSITION_BITS = 24,
	parameter int LINE_BITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stsc_pkg::q_head_t head,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output stsc_pkg::tok_t    out_tok,
	output logic              out_last
);
	import stsc_pkg::*;

	localparam logic [POSITION_BITS-1:0] PMAX = {POSITION_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]     LMAX = {LINE_BITS{1'b1}};

	function automatic logic [23:0] to_start(input logic [POSITION_BITS-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[23:0];
	endfunction

	function automatic logic [19:0] to_line(input logic [LINE_BITS-1:0] l);
		logic [31:0] w;
		w = 32'(l);
		return w[19:0];
	endfunction

	function automatic logic [15:0] sat_len(input logic [POSITION_BITS-1:0] d);
		logic [31:0] w;
		w = 32'(d);
		return (w > 32'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [15:0] col_of(input logic [POSITION_BITS-1:0] d);
		logic [31:0] w;
		w = 32'(d);
		return (w >= 32'd65534) ? 16'hFFFF : 16'(w + 32'd1);
	endfunction

	// State
	char_t                    win_q [3];
	logic [1:0]               cnt_q;
	logic                     at_end_q;
	logic                     call_act_q;
	logic                     halted_q;
	logic [3:0]               mode_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] lso_q;
	logic [POSITION_BITS-1:0] tbeg_q;
	logic [LINE_BITS-1:0]     line_q;
	logic [LINE_BITS-1:0]     tline_q;
	logic [15:0]              tcol_q;
	logic [63:0]              acc_q;
	tok_t                     pend_q;
	logic                     pend_v_q;
	logic                     pend_fin_q;
	tok_t                     out_q;
	logic                     out_v_q;
	logic                     last_q;

	// Step datapath
	char_t                    ew [3];
	logic [1:0]               en;
	logic                     ae;
	char_t                    c0;
	char_t                    c1;
	char_t                    c2;
	logic [POSITION_BITS-1:0] pos1;
	logic [POSITION_BITS-1:0] pos2;
	logic [15:0]              col_now;
	tok_t                     here_tok;
	tok_t                     run_tok;
	logic                     nm;
	logic [1:0]               k;
	logic                     lb;
	logic                     latch;
	logic                     skip_delim;
	logic                     stop;
	logic                     emit;
	tok_t                     etok;
	logic [3:0]               mode_n;
	logic [63:0]              acc_n;
	char_t                    w_n [3];
	logic [1:0]               cnt_n;
	logic [POSITION_BITS-1:0] pos_n;
	logic [POSITION_BITS-1:0] lso_n;
	logic [LINE_BITS-1:0]     line_n;
	logic                     done;
	logic                     go;
	logic                     out_free;
	logic                     push_out;
	logic                     push_last;

	// Window that this step sees: the held bytes plus the new byte at call start.
	always_comb begin
		ew = win_q;
		en = cnt_q;
		ae = at_end_q;
		if (!call_act_q) begin
			ae = head.ch.is_end;
			if (!head.ch.is_end) begin
				ew[cnt_q] = head.ch;
				en = cnt_q + 2'd1;
			end
		end
		c0 = (en > 2'd0) ? ew[0] : CH_NONE;
		c1 = (en > 2'd1) ? ew[1] : CH_NONE;
		c2 = (en > 2'd2) ? ew[2] : CH_NONE;
	end

	assign pos1 = (pos_q == PMAX) ? pos_q : pos_q + 1'b1;
	assign pos2 = (pos1 == PMAX) ? pos1 : pos1 + 1'b1;
	assign col_now = col_of(pos_q - lso_q);

	always_comb begin
		here_tok.kind = KIND_EOF;
		here_tok.start = to_start(pos_q);
		here_tok.length = 16'd1;
		here_tok.line = to_line(line_q);
		here_tok.column = col_now;
		here_tok.value = '0;
		run_tok.kind = KIND_EOF;
		run_tok.start = to_start(tbeg_q);
		run_tok.length = sat_len(pos_q - tbeg_q);
		run_tok.line = to_line(tline_q);
		run_tok.column = tcol_q;
		run_tok.value = '0;
	end

	// One scan step
	always_comb begin
		nm = need_more(mode_q, en, ae, c0, c1);
		k = 2'd0;
		lb = 1'b0;
		latch = 1'b0;
		skip_delim = 1'b0;
		stop = 1'b0;
		emit = 1'b0;
		etok = here_tok;
		mode_n = mode_q;
		acc_n = acc_q;
		if (!nm) begin
			case (mode_q)
				MODE_IDLE: begin
					if (c0.code == CH_NUL) begin
						stop = 1'b1;
					end else if (c0.code inside {CH_SPACE, CH_TAB, CH_CR}) begin
						k = 2'd1;
					end else if (c0.code == CH_NL) begin
						emit = 1'b1;
						etok.kind = KIND_NEWLINE;
						k = 2'd1;
						lb = 1'b1;
					end else if (c0.code == CH_HASH) begin
						mode_n = MODE_COMMENT;
						k = 2'd1;
					end else if (c0.code == CH_DOT) begin
						if (c1.code == CH_DOT) begin
							emit = 1'b1;
							etok.kind = KIND_DOTDOT;
							etok.length = 16'd2;
							k = 2'd2;
						end else begin
							latch = 1'b1;
							k = 2'd1;
							mode_n = MODE_IDENT;
						end
					end else if (c0.code == CH_BANG) begin
						if (c1.code == CH_EQ) begin
							emit = 1'b1;
							etok.kind = KIND_IDENT;
							etok.length = 16'd2;
							k = 2'd2;
						end else if (c1.is_alnum || (c1.code == CH_MINUS) ||
							(c1.code == CH_UNDER)) begin
							latch = 1'b1;
							skip_delim = 1'b1;
							k = 2'd1;
							mode_n = MODE_PRAGMA;
						end else begin
							emit = 1'b1;
							etok.kind = KIND_IDENT;
							k = 2'd1;
						end
					end else if (c0.is_digit) begin
						latch = 1'b1;
						acc_n = {60'd0, c0.code[3:0]};
						k = 2'd1;
						mode_n = MODE_INT;
					end else if (c0.code == CH_QUOTE) begin
						latch = 1'b1;
						skip_delim = 1'b1;
						k = 2'd1;
						mode_n = MODE_STR;
					end else if (c0.code inside {CH_COLON, CH_LBRACE, CH_RBRACE, CH_LBRACK,
						CH_RBRACK, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI}) begin
						emit = 1'b1;
						k = 2'd1;
						case (c0.code)
							CH_COLON:  etok.kind = KIND_COLON;
							CH_LBRACE: etok.kind = KIND_LBRACE;
							CH_RBRACE: etok.kind = KIND_RBRACE;
							CH_LBRACK: etok.kind = KIND_LBRACK;
							CH_RBRACK: etok.kind = KIND_RBRACK;
							CH_LPAREN: etok.kind = KIND_LPAREN;
							CH_RPAREN: etok.kind = KIND_RPAREN;
							CH_COMMA:  etok.kind = KIND_COMMA;
							default:   etok.kind = KIND_IDENT;
						endcase
					end else if (c0.is_nameop) begin
						latch = 1'b1;
						k = 2'd1;
						mode_n = MODE_IDENT;
					end else begin
						stop = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if ((c0.code == CH_NUL) || (c0.code == CH_NL)) begin
						mode_n = MODE_IDLE;
					end else begin
						k = 2'd1;
					end
				end
				MODE_IDENT: begin
					if (c0.is_nameop) begin
						k = 2'd1;
					end else begin
						emit = 1'b1;
						etok = run_tok;
						etok.kind = KIND_IDENT;
						mode_n = MODE_IDLE;
					end
				end
				MODE_PRAGMA: begin
					if (c0.is_name) begin
						k = 2'd1;
					end else begin
						emit = 1'b1;
						etok = run_tok;
						etok.kind = KIND_PRAGMA;
						mode_n = MODE_IDLE;
					end
				end
				MODE_INT: begin
					if (c0.is_digit) begin
						acc_n = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} +
							{60'd0, c0.code[3:0]};
						k = 2'd1;
					end else if ((c0.code == CH_DOT) && c1.is_digit) begin
						k = 2'd1;
						mode_n = MODE_FRAC;
					end else begin
						emit = 1'b1;
						etok = run_tok;
						etok.kind = KIND_INT;
						etok.value = acc_q;
						mode_n = MODE_IDLE;
					end
				end
				MODE_FRAC: begin
					if (c0.is_digit) begin
						k = 2'd1;
					end else if (((c0.code == CH_LE) || (c0.code == CH_UE)) && c1.is_digit) begin
						k = 2'd1;
						mode_n = MODE_EXP;
					end else if (((c0.code == CH_LE) || (c0.code == CH_UE)) &&
						((c1.code == CH_PLUS) || (c1.code == CH_MINUS)) && c2.is_digit) begin
						k = 2'd2;
						mode_n = MODE_EXP;
					end else begin
						emit = 1'b1;
						etok = run_tok;
						etok.kind = KIND_FLOAT;
						etok.value = acc_q;
						mode_n = MODE_IDLE;
					end
				end
				MODE_EXP: begin
					if (c0.is_digit) begin
						k = 2'd1;
					end else begin
						emit = 1'b1;
						etok = run_tok;
						etok.kind = KIND_FLOAT;
						etok.value = acc_q;
						mode_n = MODE_IDLE;
					end
				end
				MODE_STR: begin
					if ((c0.code == CH_NUL) || (c0.code == CH_QUOTE)) begin
						emit = 1'b1;
						etok = run_tok;
						etok.kind = KIND_STRING;
						mode_n = MODE_IDLE;
						k = (c0.code == CH_QUOTE) ? 2'd1 : 2'd0;
					end else begin
						k = 2'd1;
						lb = (c0.code == CH_NL);
						if (c0.code == CH_BSLASH) begin
							mode_n = MODE_ESC;
						end
					end
				end
				default: begin
					// Escape: the byte after a backslash is taken as is.
					k = (c0.code != CH_NUL) ? 2'd1 : 2'd0;
					mode_n = MODE_STR;
				end
			endcase
		end
		if (stop) begin
			emit = 1'b1;
			etok = here_tok;
			etok.kind = KIND_EOF;
			etok.length = 16'd0;
			mode_n = MODE_IDLE;
		end
	end

	// Consume, line break and the end-of-call check
	always_comb begin
		w_n = ew;
		cnt_n = en;
		pos_n = pos_q;
		case (k)
			2'd1: begin
				w_n[0] = ew[1];
				w_n[1] = ew[2];
				cnt_n = en - 2'd1;
				pos_n = pos1;
			end
			2'd2: begin
				w_n[0] = ew[2];
				cnt_n = en - 2'd2;
				pos_n = pos2;
			end
			default: begin
				pos_n = pos_q;
			end
		endcase
		if (stop) begin
			cnt_n = 2'd0;
		end
		line_n = line_q;
		lso_n = lso_q;
		if (lb) begin
			line_n = (line_q == LMAX) ? line_q : line_q + 1'b1;
			lso_n = pos_n;
		end
		done = nm || stop || need_more(mode_n, cnt_n, ae,
			(cnt_n > 2'd0) ? w_n[0] : CH_NONE, (cnt_n > 2'd1) ? w_n[1] : CH_NONE);
	end

	// Handshake: a result is held one slot back until the next one, or the
	// end of its call, tells whether it is the last of that call.
	assign out_free = !out_v_q || !out_stall;
	assign go = (call_act_q || (head.valid && !halted_q)) && (!pend_v_q || out_free);
	assign pop = !call_act_q && head.valid && (halted_q || go);
	assign push_out = out_free && pend_v_q && (pend_fin_q || (go && (emit || done)));
	assign push_last = pend_fin_q || (go && done && !emit);

	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i] <= w_n[i];
			end
			if (!call_act_q) begin
				at_end_q <= ae;
			end
			tcol_q <= latch ? col_now : tcol_q;
			tline_q <= latch ? line_q : tline_q;
			tbeg_q <= skip_delim ? pos1 : (latch ? pos_q : tbeg_q);
			acc_q <= acc_n;
			if (emit) begin
				pend_q <= etok;
			end
		end
		if (push_out) begin
			out_q <= pend_q;
			last_q <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			call_act_q <= 1'b0;
			halted_q <= 1'b0;
			mode_q <= MODE_IDLE;
			pos_q <= '0;
			lso_q <= '0;
			line_q <= LINE_BITS'(1);
			pend_v_q <= 1'b0;
			pend_fin_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (go) begin
				cnt_q <= cnt_n;
				call_act_q <= !done;
				halted_q <= stop;
				mode_q <= mode_n;
				pos_q <= pos_n;
				lso_q <= lso_n;
				line_q <= line_n;
			end
			if (go && emit) begin
				pend_v_q <= 1'b1;
				pend_fin_q <= done;
			end else if (push_out) begin
				pend_v_q <= 1'b0;
				pend_fin_q <= 1'b0;
			end
			if (out_free) begin
				out_v_q <= push_out;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_tok = out_q;
	assign out_last = last_q;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("scanner left the halted state");
	a_fin_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_fin_q |-> pend_v_q)
		else $error("final flag without a pending token");
	a_no_call_halted: assert property (@(posedge clk) disable iff (!arst_n)
		call_act_q |-> !halted_q)
		else $error("scan call open while halted");
	a_room_for_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!call_act_q |-> (cnt_q != 2'd3))
		else $error("window full between calls");
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (out_q.kind == KIND_EOF)) |-> last_q)
		else $error("EOF token not marked last");

endmodule

// ----- design/source_token_scanner_core.sv -----
// ----------------------------------------------------------------------
// Source token scanner core
// Byte in, tokens out. The input channel carries one source byte per
// transfer (or an end-of-input mark); the output channel carries one token
// per transfer, with last set on the final token caused by an input byte.
// A front end classifies bytes into a four entry queue; the back end runs
// one scan step per cycle while it has work and the output has room. A byte
// that only extends a token needs just its own step; each emitted token
// adds about one step, all run by the single scan step unit. Reset clears
// the queue, returns the scanner to line one, offset zero and clears the
// halted flag. When the receiver stalls, the output register holds its
// token, one more token waits in the pending slot, and the queue then
// fills and stalls the input. After an EOF token every later byte is taken
// and dropped until reset.
// ----------------------------------------------------------------------
module source_token_scanner_core #(
	parameter int POSITION_BITS = 24,
	parameter int LINE_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [23:0] token_start,
	output logic [15:0] token_length,
	output logic [19:0] token_line,
	output logic [15:0] token_column,
	output logic [63:0] int_value,
	output logic        last
);
	import stsc_pkg::*;

	// Head of the byte queue and the pop request back to the front.
	q_head_t head;
	logic    pop;
	tok_t    tok;

	// The front takes one byte per transfer whenever the queue has room and
	// tags it with its character class, so the back end decodes narrow flags.
	stsc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.head         (head),
		.pop          (pop)
	);

	// The back end owns all scan state: mode, offsets, line counters, the
	// three byte lookahead window and the integer accumulator.
	stsc_back #(
		.POSITION_BITS (POSITION_BITS),
		.LINE_BITS     (LINE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_tok   (tok),
		.out_last  (last)
	);

	assign token_kind = tok.kind;
	assign token_start = tok.start;
	assign token_length = tok.length;
	assign token_line = tok.line;
	assign token_column = tok.column;
	assign int_value = tok.value;

endmodule

// ----- verif/token_stream_checker.sv -----
// ----------------------------------------------------------------------
// Token stream checker
// Watches both channels of the source token scanner, predicts the tokens
// that every accepted source byte releases and compares each accepted
// token against the oldest prediction.
// ----------------------------------------------------------------------
module token_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  token_kind,
	input  logic [23:0] token_start,
	input  logic [15:0] token_length,
	input  logic [19:0] token_line,
	input  logic [15:0] token_column,
	input  logic [63:0] int_value,
	input  logic        last,
	output int          errors,
	output int          pending
);
	import stsc_pkg::*;

	localparam logic [8:0]  NEED_BYTE = 9'h100;
	localparam logic [63:0] POS_MAX   = (64'd1 << 24) - 64'd1;
	localparam logic [63:0] LINE_MAX  = (64'd1 << 20) - 64'd1;

	typedef struct packed {
		tok_t tok;
		logic fin;
	} token_word_t;

	token_word_t expected_tokens[$];
	token_word_t burst[3];
	int          burst_n;

	logic [3:0]  mode;
	logic [63:0] pos, line_no, line_begin, run_begin, run_line, run_col, acc;
	logic [8:0]  win[3];
	int          win_n;
	logic [7:0]  held[2];
	int          held_n;
	logic        at_end, halted;

	function logic dig(input logic [8:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function logic alnum(input logic [8:0] c);
		return dig(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function logic namech(input logic [8:0] c);
		return alnum(c) || c == CH_UNDER || c == CH_MINUS || c == CH_QMARK ||
			c == CH_EQ || c == CH_DOT;
	endfunction

	function logic nameop(input logic [8:0] c);
		return namech(c) || c == CH_PLUS || c == CH_STAR || c == CH_SLASH ||
			c == CH_PCT || c == CH_AT || c == CH_LT || c == CH_GT || c == CH_BANG ||
			c == CH_AMP || c == CH_BAR || c == CH_CARET;
	endfunction

	function logic [8:0] peek(input int i);
		if (i < win_n) return win[i];
		return at_end ? 9'd0 : NEED_BYTE;
	endfunction

	function void consume(input int k);
		for (int i = 0; i < k && win_n > 0; i++) begin
			win[0] = win[1];
			win[1] = win[2];
			win_n--;
			if (pos < POS_MAX) pos++;
		end
	endfunction

	function logic [63:0] col_now();
		logic [63:0] d;
		d = pos - line_begin;
		return d >= 64'd65534 ? 64'd65535 : d + 64'd1;
	endfunction

	function void new_line();
		if (line_no < LINE_MAX) line_no++;
		line_begin = pos;
	endfunction

	function void put(input logic [3:0] kind, input logic [63:0] start,
		input logic [63:0] len, input logic [63:0] ln, input logic [63:0] col,
		input logic [63:0] val);
		if (burst_n >= 3) return;
		burst[burst_n].tok.kind   = kind;
		burst[burst_n].tok.start  = start[23:0];
		burst[burst_n].tok.length = len > 64'd65535 ? 16'hFFFF : len[15:0];
		burst[burst_n].tok.line   = ln[19:0];
		burst[burst_n].tok.column = col[15:0];
		burst[burst_n].tok.value  = val;
		burst[burst_n].fin        = 1'b0;
		burst_n++;
	endfunction

	function void put_here(input logic [3:0] kind, input logic [63:0] len);
		put(kind, pos, len, line_no, col_now(), 64'd0);
	endfunction

	function void close_run(input logic [3:0] kind);
		put(kind, run_begin, pos - run_begin, run_line, run_col,
			(kind == KIND_INT || kind == KIND_FLOAT) ? acc : 64'd0);
		mode = MODE_IDLE;
	endfunction

	function void open_run();
		run_begin = pos;
		run_line  = line_no;
		run_col   = col_now();
	endfunction

	function void halt_scan();
		put_here(KIND_EOF, 64'd0);
		halted = 1'b1;
		win_n  = 0;
		mode   = MODE_IDLE;
	endfunction

	// One scan step; returns 0 when more bytes are needed or the scanner halted.
	function logic scan_step();
		logic [8:0] c, c1, c2;
		c = peek(0);
		if (c == NEED_BYTE) return 1'b0;
		case (mode)
			MODE_IDLE: begin
				if (c == 9'd0) begin
					halt_scan();
					return 1'b0;
				end
				if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
					consume(1);
					return 1'b1;
				end
				if (c == CH_NL) begin
					put_here(KIND_NEWLINE, 64'd1);
					consume(1);
					new_line();
					return 1'b1;
				end
				if (c == CH_HASH) begin
					mode = MODE_COMMENT;
					consume(1);
					return 1'b1;
				end
				if (c == CH_DOT) begin
					c1 = peek(1);
					if (c1 == NEED_BYTE) return 1'b0;
					if (c1 == CH_DOT) begin
						put_here(KIND_DOTDOT, 64'd2);
						consume(2);
						return 1'b1;
					end
					open_run();
					consume(1);
					mode = MODE_IDENT;
					return 1'b1;
				end
				if (c == CH_BANG) begin
					c1 = peek(1);
					if (c1 == NEED_BYTE) return 1'b0;
					if (c1 == CH_EQ) begin
						put_here(KIND_IDENT, 64'd2);
						consume(2);
						return 1'b1;
					end
					if (alnum(c1) || c1 == CH_MINUS || c1 == CH_UNDER) begin
						open_run();
						consume(1);
						run_begin = pos;
						mode = MODE_PRAGMA;
						return 1'b1;
					end
					put_here(KIND_IDENT, 64'd1);
					consume(1);
					return 1'b1;
				end
				if (dig(c)) begin
					open_run();
					acc = 64'(c - CH_0);
					consume(1);
					mode = MODE_INT;
					return 1'b1;
				end
				if (c == CH_QUOTE) begin
					open_run();
					consume(1);
					run_begin = pos;
					mode = MODE_STR;
					return 1'b1;
				end
				case (c)
					CH_COLON:  put_here(KIND_COLON, 64'd1);
					CH_LBRACE: put_here(KIND_LBRACE, 64'd1);
					CH_RBRACE: put_here(KIND_RBRACE, 64'd1);
					CH_LBRACK: put_here(KIND_LBRACK, 64'd1);
					CH_RBRACK: put_here(KIND_RBRACK, 64'd1);
					CH_LPAREN: put_here(KIND_LPAREN, 64'd1);
					CH_RPAREN: put_here(KIND_RPAREN, 64'd1);
					CH_COMMA:  put_here(KIND_COMMA, 64'd1);
					CH_SEMI:   put_here(KIND_IDENT, 64'd1);
					default: begin
						if (nameop(c)) begin
							open_run();
							consume(1);
							mode = MODE_IDENT;
							return 1'b1;
						end
						halt_scan();
						return 1'b0;
					end
				endcase
				consume(1);
				return 1'b1;
			end
			MODE_COMMENT: begin
				if (c == 9'd0 || c == CH_NL) mode = MODE_IDLE;
				else consume(1);
				return 1'b1;
			end
			MODE_IDENT: begin
				if (nameop(c)) consume(1);
				else close_run(KIND_IDENT);
				return 1'b1;
			end
			MODE_PRAGMA: begin
				if (namech(c)) consume(1);
				else close_run(KIND_PRAGMA);
				return 1'b1;
			end
			MODE_INT: begin
				if (dig(c)) begin
					acc = acc * 64'd10 + 64'(c - CH_0);
					consume(1);
					return 1'b1;
				end
				if (c == CH_DOT) begin
					c1 = peek(1);
					if (c1 == NEED_BYTE) return 1'b0;
					if (dig(c1)) begin
						consume(1);
						mode = MODE_FRAC;
						return 1'b1;
					end
				end
				close_run(KIND_INT);
				return 1'b1;
			end
			MODE_FRAC: begin
				if (dig(c)) begin
					consume(1);
					return 1'b1;
				end
				if (c == CH_LE || c == CH_UE) begin
					c1 = peek(1);
					if (c1 == NEED_BYTE) return 1'b0;
					if (dig(c1)) begin
						consume(1);
						mode = MODE_EXP;
						return 1'b1;
					end
					if (c1 == CH_PLUS || c1 == CH_MINUS) begin
						c2 = peek(2);
						if (c2 == NEED_BYTE) return 1'b0;
						if (dig(c2)) begin
							consume(2);
							mode = MODE_EXP;
							return 1'b1;
						end
					end
				end
				close_run(KIND_FLOAT);
				return 1'b1;
			end
			MODE_EXP: begin
				if (dig(c)) consume(1);
				else close_run(KIND_FLOAT);
				return 1'b1;
			end
			MODE_STR: begin
				if (c == 9'd0) begin
					close_run(KIND_STRING);
					return 1'b1;
				end
				if (c == CH_QUOTE) begin
					close_run(KIND_STRING);
					consume(1);
					return 1'b1;
				end
				if (c == CH_NL) begin
					consume(1);
					new_line();
					return 1'b1;
				end
				consume(1);
				if (c == CH_BSLASH) mode = MODE_ESC;
				return 1'b1;
			end
			default: begin
				// Escaped byte: skipped unless it is zero, so a newline here is no line break.
				if (c != 9'd0) consume(1);
				mode = MODE_STR;
				return 1'b1;
			end
		endcase
	endfunction

	function void scan_byte(input logic [7:0] code, input logic eoi);
		if (halted) return;
		burst_n = 0;
		win_n   = held_n;
		win[0]  = {1'b0, held[0]};
		win[1]  = {1'b0, held[1]};
		win[2]  = 9'd0;
		at_end  = eoi || code == CH_NUL;
		if (!at_end) begin
			win[win_n] = {1'b0, code};
			win_n++;
		end
		while (scan_step()) ;
		if (win_n > 2) win_n = 2;
		held_n = win_n;
		for (int i = 0; i < 2; i++) held[i] = i < win_n ? win[i][7:0] : 8'd0;
		for (int i = 0; i < burst_n; i++) begin
			burst[i].fin = (i == burst_n - 1);
			expected_tokens.push_back(burst[i]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_word_t seen, want;
		if (!arst_n) begin
			mode = MODE_IDLE;
			pos = 0;
			line_no = 1;
			line_begin = 0;
			run_begin = 0;
			run_line = 1;
			run_col = 1;
			acc = 0;
			held[0] = 0;
			held[1] = 0;
			held_n = 0;
			halted = 1'b0;
			expected_tokens.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{'{token_kind, token_start, token_length, token_line,
					token_column, int_value}, last};
				if (expected_tokens.size() == 0) begin
					errors++;
					$display("%0t: token with none expected: %p", $time, seen);
				end else begin
					want = expected_tokens.pop_front();
					if (seen !== want) begin
						errors++;
						$display("%0t: token mismatch expected %p actual %p", $time, want, seen);
					end
				end
			end
			if (in_valid && !in_stall) scan_byte(char_code, end_of_input);
			pending = expected_tokens.size();
		end
	end

endmodule

// ----- verif/tb_source_token_scanner_core.sv -----
// ----------------------------------------------------------------------
// Source token scanner testbench
// Feeds source text to the scanner one byte per transfer: a few directed
// lines, then random token-shaped text under three idling patterns,
// closing with an end of source. A separate checker predicts and compares
// every token.
// ----------------------------------------------------------------------
module tb_source_token_scanner_core;

	import stsc_pkg::*;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_code = 8'd0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  token_kind;
	logic [23:0] token_start;
	logic [15:0] token_length;
	logic [19:0] token_line;
	logic [15:0] token_column;
	logic [63:0] int_value;
	logic        last;
	int          errors;
	int          pending;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int          send_idle_pct = 31;
	int          take_stall_pct = 54;
	// Set by the stimulus to ask the receiver for one long hold-off.
	logic        hold_req = 1'b0;

	logic [7:0]  text_q[$];

	source_token_scanner_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_code(char_code), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .token_start(token_start),
		.token_length(token_length), .token_line(token_line),
		.token_column(token_column), .int_value(int_value), .last(last)
	);

	token_stream_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_code(char_code), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .token_start(token_start),
		.token_length(token_length), .token_line(token_line),
		.token_column(token_column), .int_value(int_value), .last(last),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run is bounded well beyond the slowest legal run.
	initial begin
		#(8 * 200000);
		$display("Mismatches found");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request so that the
	// output register, the pending slot and the byte queue all fill up.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end
			out_stall <= ($urandom_range(99) < take_stall_pct);
		end
	end

	// Sends one byte and returns once the transfer has happened.
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		char_code    <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_text();
		foreach (text_q[i]) send_byte(text_q[i], 1'b0);
		text_q.delete();
	endtask

	function automatic void put_str(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	function automatic void put_digits(input int n);
		repeat (n) text_q.push_back(pick("0123456789"));
	endfunction

	// Any byte but zero, newline, quote and backslash; the high half is the
	// only way bit seven is reached, since such bytes end the scan elsewhere.
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255));
		while (b == CH_NL || b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic void put_string_body();
		repeat ($urandom_range(8)) begin
			case ($urandom_range(5))
				0: text_q.push_back(CH_NL);
				1: begin
					// Escape pair; the escaped byte may be a quote or a newline.
					text_q.push_back(CH_BSLASH);
					text_q.push_back($urandom_range(1) ? body_byte() :
						pick("\"\n\\n"));
				end
				default: text_q.push_back(body_byte());
			endcase
		end
	endfunction

	function automatic void put_comment_body();
		logic [7:0] b;
		repeat ($urandom_range(6)) begin
			b = $urandom_range(1) ? body_byte() : pick("\"\\#");
			text_q.push_back(b);
		end
	endfunction

	// One random, mostly well-formed piece of source text.
	function automatic void put_piece();
		case ($urandom_range(15))
			0, 1: begin
				text_q.push_back(pick("abcxyzAMZ_-?=+*/%@<>&|^"));
				repeat ($urandom_range(5))
					text_q.push_back(pick("az09AZ_-?=.+*/%@<>!&|^"));
			end
			2: put_digits($urandom_range(1, 22));
			3: begin
				put_digits($urandom_range(1, 3));
				text_q.push_back(CH_DOT);
				put_digits($urandom_range(1, 3));
				if ($urandom_range(1)) begin
					text_q.push_back(pick("eE"));
					if ($urandom_range(1)) text_q.push_back(pick("+-"));
					put_digits($urandom_range(1, 2));
				end
			end
			4: begin
				// Numbers cut short: no fraction digit, or a broken exponent.
				put_digits($urandom_range(1, 2));
				case ($urandom_range(3))
					0: put_str(".x");
					1: put_str("e5");
					2: put_str("..");
					default: begin
						put_str(".5");
						text_q.push_back(pick("eE"));
						if ($urandom_range(1)) text_q.push_back(pick("+-"));
						text_q.push_back(pick("x;,"));
					end
				endcase
			end
			5, 6: begin
				text_q.push_back(CH_QUOTE);
				put_string_body();
				text_q.push_back(CH_QUOTE);
			end
			7: begin
				text_q.push_back(CH_HASH);
				put_comment_body();
				text_q.push_back(CH_NL);
			end
			8: begin
				text_q.push_back(CH_BANG);
				text_q.push_back(pick("aZ09_-"));
				repeat ($urandom_range(4)) text_q.push_back(pick("az09_-?=."));
			end
			9: put_str($urandom_range(1) ? "!=" : "! ");
			10, 11: text_q.push_back(pick(":{}[](),;"));
			12: put_str($urandom_range(1) ? ".." : ".q");
			13: text_q.push_back(pick(" \t\r\n"));
			default: text_q.push_back(pick("az09_-?=.+*/%@<>!&|^:{}[](),; \t\r\n"));
		endcase
		if ($urandom_range(2) == 0) text_q.push_back(pick(" \t\r\n"));
	endfunction

	task automatic random_phase(input int n_bytes);
		while (text_q.size() < n_bytes) put_piece();
		send_text();
	endtask

	initial begin
		logic [7:0] odd;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every kind of token but EOF, escaped newline in a string, a 64 bit
		// wrap of an integer, and an integer followed by an exponent.
		put_str("x 18446744073709551617 1.5e+7 1e5 \"a\\\nb\"\n!p != ! ;{}[](),:..\r\t");
		send_text();

		random_phase(85);
		send_idle_pct  = 54;
		take_stall_pct = 31;
		random_phase(85);
		send_idle_pct  = 0;
		take_stall_pct = 0;
		hold_req = 1'b1;
		random_phase(85);

		// Ending: an unterminated string or comment may be open, then the end
		// of source comes as end_of_input, a zero byte or an unknown byte.
		case ($urandom_range(2))
			0: begin
				text_q.push_back(CH_QUOTE);
				put_string_body();
			end
			1: begin
				text_q.push_back(CH_HASH);
				put_comment_body();
			end
			default: put_digits(2);
		endcase
		case ($urandom_range(2))
			0: text_q.push_back(CH_NUL);
			1: begin
				odd = $urandom_range(1) ? 8'($urandom_range(128, 255)) : pick("$'`~\x01\x7f");
				text_q.push_back(odd);
			end
			default: ;
		endcase
		send_text();
		send_byte(8'($urandom_range(255)), 1'b1);
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/stsc_pkg.sv
design/stsc_front.sv
design/stsc_back.sv
design/source_token_scanner_core.sv
verif/token_stream_checker.sv
verif/tb_source_token_scanner_core.sv
